// ----- hw/rtl/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int COORD_WIDTH_DEF = 10;
  localparam int COLOR_WIDTH     = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam int CANVAS_LEFT_RST   = 0;
  localparam int CANVAS_RIGHT_RST  = 319;
  localparam int CANVAS_TOP_RST    = 0;
  localparam int CANVAS_BOTTOM_RST = 239;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CANVAS_LEFT   = 3'd0,
    REG_CANVAS_RIGHT  = 3'd1,
    REG_CANVAS_TOP    = 3'd2,
    REG_CANVAS_BOTTOM = 3'd3,
    REG_DRAW_COLOR    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REGION_DONE = 2'd0,
    REGION_ONE  = 2'd1,
    REGION_TWO  = 2'd2
  } region_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXES,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_AB,
    ST_MUL_BA,
    ST_INIT,
    ST_EVAL
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_AXES,
    DP_MUL_AA,
    DP_MUL_BB,
    DP_MUL_AAB,
    DP_MUL_BBA,
    DP_INIT1,
    DP_INIT2,
    DP_STEP1,
    DP_STEP2,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic grad_lt;
    logic grad_gt;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hw/rtl/mer_ctrl.sv -----
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for setup and point stepping of the ellipse rasterizer.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  mer_pkg::dp_status_t status,
  output mer_pkg::dp_cmd_t    dp_cmd
);
  import mer_pkg::*;

  ctrl_state_t state, state_next;
  region_t     region, region_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      region <= REGION_DONE;
    end else begin
      state  <= state_next;
      region <= region_next;
    end
  end

  always_comb begin
    state_next  = state;
    region_next = region;
    dp_cmd.op   = DP_NOP;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_START) begin
            dp_cmd.op  = DP_LOAD;
            state_next = ST_AXES;
          end else begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_AXES: begin
        dp_cmd.op  = DP_AXES;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        dp_cmd.op  = DP_MUL_AA;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        dp_cmd.op  = DP_MUL_BB;
        state_next = ST_MUL_AB;
      end
      ST_MUL_AB: begin
        dp_cmd.op  = DP_MUL_AAB;
        state_next = ST_MUL_BA;
      end
      ST_MUL_BA: begin
        dp_cmd.op  = DP_MUL_BBA;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        dp_cmd.op   = DP_INIT1;
        region_next = REGION_ONE;
        state_next  = ST_IDLE;
      end
      ST_EVAL: begin
        if (!status.out_busy) begin
          case (region)
            REGION_ONE: begin
              if (status.grad_lt) begin
                dp_cmd.op  = DP_STEP1;
                state_next = ST_IDLE;
              end else begin
                dp_cmd.op   = DP_INIT2;
                region_next = REGION_TWO;
              end
            end
            REGION_TWO: begin
              state_next = ST_IDLE;
              if (status.grad_gt) begin
                dp_cmd.op = DP_STEP2;
              end else begin
                dp_cmd.op   = DP_FINISH;
                region_next = REGION_DONE;
              end
            end
            default: begin
              dp_cmd.op   = DP_FINISH;
              region_next = REGION_DONE;
              state_next  = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mer_datapath.sv -----
// ----------------------------------------------------------------------------
// mer_datapath
// Canvas registers, setup arithmetic with a shared multiplier, midpoint
// stepping and the result register of the ellipse rasterizer.
// ----------------------------------------------------------------------------
module mer_datapath #(
  parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mer_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic [COORD_WIDTH-1:0]             anchor_x,
  input  logic [COORD_WIDTH-1:0]             anchor_y,
  input  logic [COORD_WIDTH-1:0]             drag_x,
  input  logic [COORD_WIDTH-1:0]             drag_y,
  input  mer_pkg::dp_cmd_t                   dp_cmd,
  output mer_pkg::dp_status_t                status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [COORD_WIDTH-1:0]             x_right,
  output logic [COORD_WIDTH-1:0]             x_left,
  output logic [COORD_WIDTH-1:0]             y_lower,
  output logic [COORD_WIDTH-1:0]             y_upper,
  output logic [mer_pkg::COLOR_WIDTH-1:0]    pixel_color,
  output logic                               points_valid,
  output logic                               finished
);
  import mer_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = 3 * W + 3;

  logic [W-1:0]             canvas_left, canvas_right, canvas_top, canvas_bottom;
  logic [COLOR_WIDTH-1:0]   draw_color;

  logic [W-1:0]             ax, ay, dx, dy;
  logic [W-1:0]             dx_clamp, dy_clamp;
  logic [W-1:0]             lx, hx, ly, hy;
  logic [W:0]               sum_x, sum_y;
  logic [W-1:0]             cx_new, cy_new;

  logic [W-1:0]             center_x, center_y, semi_a, semi_b;
  logic [2*W-1:0]           a_squared, b_squared;
  logic [3*W-1:0]           aab, bba;
  logic [W-1:0]             step_x, step_y;
  logic signed [DW-1:0]     grad_x, grad_y, decision;

  logic [2*W-1:0]           mul_a;
  logic [W-1:0]             mul_b;
  logic [3*W-1:0]           product;

  logic signed [DW-1:0]     asq_d, bsq_d, aab_d, bba_d, aq_d, bq_d, two_asq, two_bsq;
  logic signed [DW-1:0]     gx_inc, gx_dec, gy_inc, gy_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_left   <= W'(CANVAS_LEFT_RST);
      canvas_right  <= W'(CANVAS_RIGHT_RST);
      canvas_top    <= W'(CANVAS_TOP_RST);
      canvas_bottom <= W'(CANVAS_BOTTOM_RST);
      draw_color    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_LEFT:   canvas_left   <= cfg_data[W-1:0];
        REG_CANVAS_RIGHT:  canvas_right  <= cfg_data[W-1:0];
        REG_CANVAS_TOP:    canvas_top    <= cfg_data[W-1:0];
        REG_CANVAS_BOTTOM: canvas_bottom <= cfg_data[W-1:0];
        REG_DRAW_COLOR:    draw_color    <= cfg_data[COLOR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (drag_x < canvas_left) begin
      dx_clamp = canvas_left + W'(1);
    end else if (drag_x > canvas_right) begin
      dx_clamp = canvas_right - W'(1);
    end else begin
      dx_clamp = drag_x;
    end
    if (drag_y < canvas_top) begin
      dy_clamp = canvas_top + W'(1);
    end else if (drag_y > canvas_bottom) begin
      dy_clamp = canvas_bottom - W'(1);
    end else begin
      dy_clamp = drag_y;
    end
  end

  always_comb begin
    lx     = (ax < dx) ? ax : dx;
    hx     = (ax < dx) ? dx : ax;
    ly     = (ay < dy) ? ay : dy;
    hy     = (ay < dy) ? dy : ay;
    sum_x  = {1'b0, lx} + {1'b0, hx};
    sum_y  = {1'b0, ly} + {1'b0, hy};
    cx_new = sum_x[W:1];
    cy_new = sum_y[W:1];
  end

  always_comb begin
    case (dp_cmd.op)
      DP_MUL_AA: begin
        mul_a = {{W{1'b0}}, semi_a};
        mul_b = semi_a;
      end
      DP_MUL_BB: begin
        mul_a = {{W{1'b0}}, semi_b};
        mul_b = semi_b;
      end
      DP_MUL_AAB: begin
        mul_a = a_squared;
        mul_b = semi_b;
      end
      DP_MUL_BBA: begin
        mul_a = b_squared;
        mul_b = semi_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = {{W{1'b0}}, mul_a} * {{(2*W){1'b0}}, mul_b};
  end

  always_comb begin
    asq_d   = {{(DW-2*W){1'b0}}, a_squared};
    bsq_d   = {{(DW-2*W){1'b0}}, b_squared};
    aab_d   = {{(DW-3*W){1'b0}}, aab};
    bba_d   = {{(DW-3*W){1'b0}}, bba};
    aq_d    = {{(DW-2*W+2){1'b0}}, a_squared[2*W-1:2]};
    bq_d    = {{(DW-2*W+2){1'b0}}, b_squared[2*W-1:2]};
    two_asq = {asq_d[DW-2:0], 1'b0};
    two_bsq = {bsq_d[DW-2:0], 1'b0};
    gx_inc  = grad_x + two_bsq;
    gx_dec  = grad_x - two_bsq;
    gy_inc  = grad_y + two_asq;
    gy_dec  = grad_y - two_asq;
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      DP_LOAD: begin
        ax <= anchor_x;
        ay <= anchor_y;
        dx <= dx_clamp;
        dy <= dy_clamp;
      end
      DP_AXES: begin
        center_x <= cx_new;
        center_y <= cy_new;
        semi_a   <= hx - cx_new;
        semi_b   <= hy - cy_new;
      end
      DP_MUL_AA:  a_squared <= product[2*W-1:0];
      DP_MUL_BB:  b_squared <= product[2*W-1:0];
      DP_MUL_AAB: aab       <= product;
      DP_MUL_BBA: bba       <= product;
      DP_INIT1: begin
        step_x   <= '0;
        step_y   <= semi_b;
        grad_x   <= '0;
        grad_y   <= {aab_d[DW-2:0], 1'b0};
        decision <= bsq_d - aab_d + aq_d;
      end
      DP_INIT2: begin
        step_x   <= semi_a;
        step_y   <= '0;
        grad_x   <= {bba_d[DW-2:0], 1'b0};
        grad_y   <= '0;
        decision <= asq_d - bba_d + bq_d;
      end
      DP_STEP1: begin
        step_x <= step_x + W'(1);
        grad_x <= gx_inc;
        if (decision[DW-1]) begin
          decision <= decision + gx_inc + bsq_d;
        end else begin
          step_y   <= step_y - W'(1);
          grad_y   <= gy_dec;
          decision <= decision + gx_inc - gy_dec + bsq_d;
        end
      end
      DP_STEP2: begin
        step_y <= step_y + W'(1);
        grad_y <= gy_inc;
        if (decision[DW-1]) begin
          decision <= decision + gy_inc + asq_d;
        end else begin
          step_x   <= step_x - W'(1);
          grad_x   <= gx_dec;
          decision <= decision + gy_inc - gx_dec + asq_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == DP_STEP1 || dp_cmd.op == DP_STEP2) begin
      x_right      <= center_x + step_x;
      x_left       <= center_x - step_x;
      y_lower      <= center_y + step_y;
      y_upper      <= center_y - step_y;
      pixel_color  <= draw_color;
      points_valid <= 1'b1;
      finished     <= 1'b0;
    end else if (dp_cmd.op == DP_FINISH) begin
      x_right      <= '0;
      x_left       <= '0;
      y_lower      <= '0;
      y_upper      <= '0;
      pixel_color  <= draw_color;
      points_valid <= 1'b0;
      finished     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.op == DP_STEP1 || dp_cmd.op == DP_STEP2 ||
                 dp_cmd.op == DP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.grad_lt  = grad_x < grad_y;
  assign status.grad_gt  = grad_x > grad_y;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ----- hw/rtl/midpoint_ellipse_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse rasterizer: a start transaction sets up an ellipse from two
// corners; each next transaction returns a group of four symmetric points or an end marker.
// ----------------------------------------------------------------------------
// Setup: a start transaction holds s_tready low through the center step, the four
// multiplies on one shared multiplier and the initial terms, then raises it again.
// A next transaction goes to the evaluate step, which waits while a result stalls,
// first loads the region 2 terms when crossing from region 1 to region 2, and then
// fills the result register behind m_tvalid; s_tready stays low until it is done.
// Reset clears control state and the result valid flag and loads the canvas reset bounds.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mer_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // anchor_x, anchor_y, drag_x, drag_y, zero fill
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
  // cmd
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // x_right, x_left, y_lower, y_upper, pixel_color, zero fill
  output logic [((4*COORD_WIDTH+mer_pkg::COLOR_WIDTH+7)/8)*8-1:0] m_tdata,
  // points_valid, finished
  output logic [1:0]                          m_tuser
);
  import mer_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int OUT_RAW = 4 * W + COLOR_WIDTH;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  dp_cmd_t                dp_cmd;
  dp_status_t             status;
  logic [W-1:0]           x_right, x_left, y_lower, y_upper;
  logic [COLOR_WIDTH-1:0] pixel_color;
  logic                   points_valid, finished;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .status   (status),
    .dp_cmd   (dp_cmd)
  );

  mer_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .anchor_x     (s_tdata[W-1:0]),
    .anchor_y     (s_tdata[2*W-1:W]),
    .drag_x       (s_tdata[3*W-1:2*W]),
    .drag_y       (s_tdata[4*W-1:3*W]),
    .dp_cmd       (dp_cmd),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .x_right      (x_right),
    .x_left       (x_left),
    .y_lower      (y_lower),
    .y_upper      (y_upper),
    .pixel_color  (pixel_color),
    .points_valid (points_valid),
    .finished     (finished)
  );

  assign m_tdata = OUT_W'({pixel_color, y_upper, y_lower, x_left, x_right});
  assign m_tuser = {finished, points_valid};

endmodule

// ----- hw/rtl/mer_checker.sv -----
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks of the ellipse rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mer_checker #(
  parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((4*COORD_WIDTH+mer_pkg::COLOR_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [1:0]                          m_tuser
);
  import mer_pkg::*;

  localparam int W = COORD_WIDTH;

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] != m_tuser[1]))
    else $error("Result must carry exactly one of points_valid and finished.");

  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[4*W-1:0] == '0))
    else $error("Finished result carries nonzero point coordinates.");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_START && !m_tvalid) |=> !m_tvalid)
    else $error("Start transaction produced a result.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Input accepted again directly after a transaction.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("Stalled result changed or was dropped.");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_mer_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the midpoint ellipse rasterizer. Start and next
// commands go in on the input stream while a behavioral copy of the midpoint
// algorithm predicts every point group. Each output transaction is checked
// against the oldest prediction. The canvas bounds and color are swept through
// normal, full-range, inconsistent and wrapping settings, and both stream sides
// idle at random. One long output stall backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top;

  import mer_pkg::*;

  localparam int CW       = COORD_WIDTH_DEF;
  localparam int S_W      = ((4*CW+7)/8)*8;
  localparam int M_W      = ((4*CW+COLOR_WIDTH+7)/8)*8;
  localparam int LIMIT    = 400000;
  localparam int SETTLE   = 16;
  localparam int COORD_MX = (1 << CW) - 1;

  typedef struct packed {
    logic          cmd;
    logic [CW-1:0] anchor_x;
    logic [CW-1:0] anchor_y;
    logic [CW-1:0] drag_x;
    logic [CW-1:0] drag_y;
  } shape_cmd_t;

  typedef struct packed {
    logic [CW-1:0]          x_right;
    logic [CW-1:0]          x_left;
    logic [CW-1:0]          y_lower;
    logic [CW-1:0]          y_upper;
    logic [COLOR_WIDTH-1:0] pixel_color;
    logic                   points_valid;
    logic                   finished;
  } point_group_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [S_W-1:0]             s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [M_W-1:0]             m_tdata;
  logic [1:0]                 m_tuser;

  midpoint_ellipse_rasterizer_top #(.COORD_WIDTH(CW)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Shadow registers and algorithm state of the predictor.
  logic [CW-1:0]          cv_left   = CW'(CANVAS_LEFT_RST);
  logic [CW-1:0]          cv_right  = CW'(CANVAS_RIGHT_RST);
  logic [CW-1:0]          cv_top    = CW'(CANVAS_TOP_RST);
  logic [CW-1:0]          cv_bottom = CW'(CANVAS_BOTTOM_RST);
  logic [COLOR_WIDTH-1:0] outline_color = '0;

  longint  ctr_x, ctr_y, rad_x, rad_y, rad_x_sq, rad_y_sq;
  longint  off_x, off_y, grad_x, grad_y, decision;
  region_t arc_region = REGION_DONE;

  point_group_t pending_groups[$];

  int  errors = 0;
  int  items_sent = 0;
  int  starts_sent = 0;
  int  groups_seen = 0;
  int  ends_seen = 0;
  int  reg_writes = 0;
  int  cycle_cnt = 0;
  int  stall_left = 0;
  int  rx_gap = 0;
  bit  tx_idle_en = 1'b0;
  bit  rx_idle_en = 1'b0;

  function automatic logic [CW-1:0] clamp_corner(logic [CW-1:0] v, logic [CW-1:0] lo,
                                                 logic [CW-1:0] hi);
    if (v < lo) return lo + 1'b1;
    if (v > hi) return hi - 1'b1;
    return v;
  endfunction

  function automatic void enter_second_arc();
    arc_region = REGION_TWO;
    off_x      = rad_x;
    off_y      = 0;
    grad_x     = 2 * rad_y_sq * rad_x;
    grad_y     = 0;
    decision   = rad_x_sq - rad_x * rad_y_sq + rad_y_sq / 4;
  endfunction

  // Advances the ellipse state by one transaction; returns 1 when it yields a group.
  function automatic bit predict_ellipse_step(input shape_cmd_t c, output point_group_t g);
    logic [CW-1:0] dxc, dyc;
    longint        lx, hx, ly, hy;
    bit            emit;
    g = '0;
    if (c.cmd == CMD_START) begin
      dxc        = clamp_corner(c.drag_x, cv_left, cv_right);
      dyc        = clamp_corner(c.drag_y, cv_top, cv_bottom);
      lx         = (c.anchor_x < dxc) ? c.anchor_x : dxc;
      hx         = (c.anchor_x < dxc) ? dxc : c.anchor_x;
      ly         = (c.anchor_y < dyc) ? c.anchor_y : dyc;
      hy         = (c.anchor_y < dyc) ? dyc : c.anchor_y;
      ctr_x      = (lx + hx) / 2;
      ctr_y      = (ly + hy) / 2;
      rad_x      = hx - ctr_x;
      rad_y      = hy - ctr_y;
      rad_x_sq   = rad_x * rad_x;
      rad_y_sq   = rad_y * rad_y;
      arc_region = REGION_ONE;
      off_x      = 0;
      off_y      = rad_y;
      grad_x     = 0;
      grad_y     = 2 * rad_x_sq * rad_y;
      decision   = rad_y_sq - rad_y * rad_x_sq + rad_x_sq / 4;
      return 1'b0;
    end
    emit = 1'b0;
    if (arc_region == REGION_ONE) begin
      if (grad_x < grad_y) emit = 1'b1;
      else enter_second_arc();
    end
    if (arc_region == REGION_TWO && !emit) begin
      if (grad_x > grad_y) emit = 1'b1;
      else arc_region = REGION_DONE;
    end
    g.pixel_color = outline_color;
    if (!emit) begin
      arc_region = REGION_DONE;
      g.finished = 1'b1;
      return 1'b1;
    end
    g.x_right      = CW'(ctr_x + off_x);
    g.x_left       = CW'(ctr_x - off_x);
    g.y_lower      = CW'(ctr_y + off_y);
    g.y_upper      = CW'(ctr_y - off_y);
    g.points_valid = 1'b1;
    if (arc_region == REGION_ONE) begin
      off_x++;
      grad_x += 2 * rad_y_sq;
      if (decision < 0) begin
        decision += grad_x + rad_y_sq;
      end else begin
        off_y--;
        grad_y -= 2 * rad_x_sq;
        decision += grad_x - grad_y + rad_y_sq;
      end
    end else begin
      off_y++;
      grad_y += 2 * rad_x_sq;
      if (decision < 0) begin
        decision += grad_y + rad_x_sq;
      end else begin
        off_x--;
        grad_x -= 2 * rad_y_sq;
        decision += grad_y - grad_x + rad_x_sq;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(input shape_cmd_t c, output bit done);
    point_group_t g;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= S_W'({c.drag_y, c.drag_x, c.anchor_y, c.anchor_x});
    do @(posedge clk); while (!s_tready);
    items_sent++;
    done = 1'b0;
    if (predict_ellipse_step(c, g)) begin
      pending_groups.push_back(g);
      done = g.finished;
    end else begin
      starts_sent++;
    end
  endtask

  task automatic run_ellipse(input int ax, input int ay, input int dx, input int dy,
                             input int cap, input int extra);
    shape_cmd_t c;
    bit         fin;
    int         k;
    c = {CMD_START, CW'(ax), CW'(ay), CW'(dx), CW'(dy)};
    send_item(c, fin);
    k = 0;
    while ((!fin && k < cap) || (fin && extra > 0)) begin
      if (fin) extra--;
      c = {CMD_NEXT, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
      send_item(c, fin);
      k++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_CANVAS_LEFT:   cv_left = CW'(val);
      REG_CANVAS_RIGHT:  cv_right = CW'(val);
      REG_CANVAS_TOP:    cv_top = CW'(val);
      REG_CANVAS_BOTTOM: cv_bottom = CW'(val);
      REG_DRAW_COLOR:    outline_color = val;
      default: ;
    endcase
  endtask

  task automatic set_canvas(input int l, input int r, input int t, input int b, input int col);
    drain();
    write_reg(REG_CANVAS_LEFT, CFG_DATA_WIDTH'(l));
    write_reg(REG_CANVAS_RIGHT, CFG_DATA_WIDTH'(r));
    write_reg(REG_CANVAS_TOP, CFG_DATA_WIDTH'(t));
    write_reg(REG_CANVAS_BOTTOM, CFG_DATA_WIDTH'(b));
    write_reg(REG_DRAW_COLOR, CFG_DATA_WIDTH'(col));
    cfg_we <= 1'b0;
  endtask

  function automatic int clip_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MX) return COORD_MX;
    return v;
  endfunction

  task automatic random_until(input int target);
    int pick, ax, ay, span;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
        ax = $urandom_range(cv_left, cv_right);
        ay = $urandom_range(cv_top, cv_bottom);
      end else begin
        ax = $urandom_range(0, COORD_MX);
        ay = $urandom_range(0, COORD_MX);
      end
      span = ($urandom_range(0, 19) == 0) ? 48 : 12;
      if (pick < 75) begin
        run_ellipse(ax, ay, clip_coord(ax + $urandom_range(0, 2*span) - span),
                    clip_coord(ay + $urandom_range(0, 2*span) - span),
                    160, $urandom_range(0, 2));
      end else if (pick < 90) begin
        run_ellipse(ax, ay, clip_coord(ax + $urandom_range(0, 2*span) - span),
                    clip_coord(ay + $urandom_range(0, 2*span) - span),
                    $urandom_range(0, 6), 0);
      end else begin
        run_ellipse($urandom_range(0, COORD_MX), $urandom_range(0, COORD_MX),
                    $urandom_range(0, COORD_MX), $urandom_range(0, COORD_MX),
                    $urandom_range(0, 3), 0);
      end
    end
  endtask

  task automatic test_after_reset();
    shape_cmd_t c;
    bit         fin;
    c = {CMD_NEXT, {4*CW{1'b1}}};
    send_item(c, fin);
    c = {CMD_NEXT, {4*CW{1'b0}}};
    send_item(c, fin);
  endtask

  task automatic test_degenerate_axes();
    run_ellipse(5, 5, 5, 5, 4, 0);
    run_ellipse(20, 20, 20, 24, 4, 0);
    run_ellipse(30, 30, 34, 30, 4, 1);
  endtask

  task automatic test_wrap_and_clamp();
    run_ellipse(0, 0, 3, 3, 20, 0);
    run_ellipse(CANVAS_RIGHT_RST, CANVAS_BOTTOM_RST, COORD_MX, COORD_MX, 20, 0);
  endtask

  task automatic test_wrapping_bounds();
    set_canvas(COORD_MX, 0, COORD_MX, 0, 16'hFFFF);
    run_ellipse(2, 2, 0, 0, 20, 0);
    run_ellipse(COORD_MX - 2, COORD_MX - 2, COORD_MX, COORD_MX, 20, 0);
    set_canvas(CANVAS_LEFT_RST, CANVAS_RIGHT_RST, CANVAS_TOP_RST, CANVAS_BOTTOM_RST, 16'h07E0);
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    stall_left = 250;
    run_ellipse(100, 100, 160, 140, 200, 2);
    drain();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap--;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      rx_gap = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_group_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0 +: CW], m_tdata[CW +: CW], m_tdata[2*CW +: CW], m_tdata[3*CW +: CW],
             m_tdata[4*CW +: COLOR_WIDTH], m_tuser[0], m_tuser[1]};
      groups_seen++;
      if (got.finished) ends_seen++;
      if (pending_groups.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected point group %p", got);
      end else begin
        want = pending_groups.pop_front();
        if (got.x_right !== want.x_right || got.x_left !== want.x_left ||
            got.y_lower !== want.y_lower || got.y_upper !== want.y_upper ||
            got.pixel_color !== want.pixel_color ||
            got.points_valid !== want.points_valid || got.finished !== want.finished) begin
          errors++;
          if (errors <= 10) $display("ERROR: point group mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Timeout after %0d cycles with %0d groups outstanding", cycle_cnt,
               pending_groups.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_degenerate_axes();
    test_wrap_and_clamp();
    test_wrapping_bounds();
    test_output_backpressure();

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_until(450);
    set_canvas(0, COORD_MX, 0, COORD_MX, 16'hFFFF);
    random_until(750);
    set_canvas(600, 400, 700, 300, $urandom_range(0, 16'hFFFF));
    random_until(900);
    set_canvas(0, 0, 0, 0, 16'h0000);
    random_until(1000);
    set_canvas($urandom_range(0, 200), $urandom_range(300, COORD_MX),
               $urandom_range(0, 200), $urandom_range(300, COORD_MX),
               $urandom_range(0, 16'hFFFF));
    random_until(1300);
    set_canvas(CANVAS_LEFT_RST, CANVAS_RIGHT_RST, CANVAS_TOP_RST, CANVAS_BOTTOM_RST,
               $urandom_range(0, 16'hFFFF));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_until(1550);
    drain();

    $display("Ran %0d transactions: %0d ellipse starts, %0d point groups (%0d end markers).",
             items_sent, starts_sent, groups_seen, ends_seen);
    $display("Swept %0d register writes over seven canvas settings; %0d mismatches.",
             reg_writes, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
